### rtl/core/top_k_select_top_defines.svh
// Assertion macros for the top-k selection RTL.
`ifndef TOP_K_SELECT_TOP_DEFINES_SVH
`define TOP_K_SELECT_TOP_DEFINES_SVH
`ifndef SYNTH
`define TKS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TKS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define TKS_ASSERT(lbl, prop, msg)
`define TKS_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

### rtl/core/tks_pkg.sv
// Shared types, constants and ranking function for top-k selection.
`default_nettype none
package tks_pkg;
  localparam int KW          = 7;
  localparam int VALUE_W     = 32;
  localparam int POS_W       = 16;
  localparam int K_MAX_DEF   = 64;
  localparam int MAX_ROW_DEF = 65536;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_DRAIN
  } tks_state_t;

  typedef struct packed {
    logic insert;
    logic trim;
    logic shift;
  } tks_ctrl_t;

  // Order-preserving key: NaN lowest, -0 equal to +0.
  function automatic logic [VALUE_W-1:0] rank_key(input logic [VALUE_W-1:0] bits);
    logic [VALUE_W-1:0] b;
    b = bits;
    if ((b[30:23] == 8'hFF) && (b[22:0] != 23'd0)) begin
      return '0;
    end
    if (b == 32'h8000_0000) begin
      b = '0;
    end
    if (b[31]) begin
      return ~b;
    end
    return b | 32'h8000_0000;
  endfunction
endpackage
`default_nettype wire

### rtl/core/top_k_select_top.sv
// Top level of the streaming top-k selector.
// Elements of a row arrive as float bit patterns, one word per cycle, with
// tlast on the last one. A chain of K_MAX cells keeps the k largest so far
// in descending order (NaN lowest, -0 equal to +0, ties to the lower
// position); every cell compares against the broadcast element in the same
// cycle and takes its own, the new, or its upper neighbor's entry. While a
// row streams in, one word is taken per cycle. After the row-end word the
// input stalls and the chain shifts toward cell 0, emitting one result per
// cycle while m_axis_tready is high (min(k, row length) results, tlast on the
// last), then returns to accepting; a row with no results still enters drain.
// k comes from cfg_wdata (values above K_MAX act as K_MAX, zero reports
// nothing); lowering k mid-row trims the list at the next element.
// Elements at positions MAX_ROW and beyond are not ranked.
`default_nettype none
`include "top_k_select_top_defines.svh"
module top_k_select_top #(
  parameter int K_MAX   = tks_pkg::K_MAX_DEF,
  parameter int MAX_ROW = tks_pkg::MAX_ROW_DEF
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  cfg_we,
  input  wire [tks_pkg::KW-1:0] cfg_wdata,     // keep_count
  input  wire                  s_axis_tvalid,
  output logic                 s_axis_tready,
  input  wire [31:0]           s_axis_tdata,  // [31:0] value
  input  wire                  s_axis_tlast,  // row_end
  output logic                 m_axis_tvalid,
  input  wire                  m_axis_tready,
  output logic [47:0]          m_axis_tdata,  // [31:0] top_value, [47:32] position
  output logic                 m_axis_tlast   // final_res
);
  import tks_pkg::*;

  localparam int CW = $clog2(MAX_ROW + 1);

  tks_state_t         state, state_next;
  logic [KW-1:0]      keep_count;
  logic [CW-1:0]      row_counter;
  logic [KW-1:0]      cap;
  logic               in_acc, out_acc, ins;
  tks_ctrl_t          ctrl;
  logic [31:0]        cnt_ext;
  logic [POS_W-1:0]   new_pos;
  logic [VALUE_W-1:0] new_key;

  // Chain wires: cell i reads index i (upper neighbor) and i+2 (lower), drives i+1.
  logic               cv [K_MAX+2];
  logic [VALUE_W-1:0] cval [K_MAX+2];
  logic [POS_W-1:0]   cpos [K_MAX+2];
  logic               ckeep [K_MAX+1];

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign cap     = (keep_count > KW'(K_MAX)) ? KW'(K_MAX) : keep_count;
  assign ins     = in_acc && (row_counter < CW'(MAX_ROW));
  assign cnt_ext = 32'(row_counter);
  assign new_pos = cnt_ext[POS_W-1:0];
  assign new_key = rank_key(s_axis_tdata);

  assign ctrl.insert = ins;
  assign ctrl.trim   = in_acc && s_axis_tlast;
  assign ctrl.shift  = out_acc;

  assign cv[0]         = 1'b0;
  assign cval[0]       = '0;
  assign cpos[0]       = '0;
  assign cv[K_MAX+1]   = 1'b0;
  assign cval[K_MAX+1] = '0;
  assign cpos[K_MAX+1] = '0;
  assign ckeep[0]      = 1'b1;

  for (genvar i = 0; i < K_MAX; i++) begin : g_cell
    tks_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .active     (KW'(i) < cap),
      .new_key    (new_key),
      .new_value  (s_axis_tdata),
      .new_pos    (new_pos),
      .prev_keep  (ckeep[i]),
      .prev_valid (cv[i]),
      .prev_value (cval[i]),
      .prev_pos   (cpos[i]),
      .next_valid (cv[i+2]),
      .next_value (cval[i+2]),
      .next_pos   (cpos[i+2]),
      .keep       (ckeep[i+1]),
      .valid_out  (cv[i+1]),
      .value_out  (cval[i+1]),
      .pos_out    (cpos[i+1])
    );
  end

  // Hold k; reset value one.
  always_ff @(posedge clk) begin
    if (rst) begin
      keep_count <= KW'(1);
    end else if (cfg_we) begin
      keep_count <= cfg_wdata;
    end
  end

  // Advance the position, saturate at MAX_ROW, clear at row end.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_counter <= '0;
    end else if (in_acc) begin
      if (s_axis_tlast) begin
        row_counter <= '0;
      end else if (ins) begin
        row_counter <= row_counter + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_acc && s_axis_tlast) state_next = ST_DRAIN;
      ST_DRAIN: if (!cv[1]) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    case (state)
      ST_IDLE:  s_axis_tready = 1'b1;
      ST_DRAIN: m_axis_tvalid = cv[1];
      default:  s_axis_tready = 1'b0;
    endcase
  end

  // Head of the chain is the output word.
  assign m_axis_tdata = {cpos[1], cval[1]};
  assign m_axis_tlast = !cv[2];

  `TKS_ASSERT(a_prefix, cv[2] |-> cv[1], "ranked list has a gap")
  `TKS_ASSERT(a_no_overlap, s_axis_tready |-> !m_axis_tvalid, "input taken while draining")
  `TKS_ASSERT_NEXT(a_last_ends, out_acc && m_axis_tlast, !m_axis_tvalid, "word after last result")
endmodule
`default_nettype wire

### rtl/core/tks_cell.sv
// One ranked slot of the insertion chain.
`default_nettype none
module tks_cell (
  input  wire                         clk,
  input  wire                         rst,
  input  tks_pkg::tks_ctrl_t          ctrl,
  input  wire                         active,
  input  wire [tks_pkg::VALUE_W-1:0]  new_key,
  input  wire [tks_pkg::VALUE_W-1:0]  new_value,
  input  wire [tks_pkg::POS_W-1:0]    new_pos,
  input  wire                         prev_keep,
  input  wire                         prev_valid,
  input  wire [tks_pkg::VALUE_W-1:0]  prev_value,
  input  wire [tks_pkg::POS_W-1:0]    prev_pos,
  input  wire                         next_valid,
  input  wire [tks_pkg::VALUE_W-1:0]  next_value,
  input  wire [tks_pkg::POS_W-1:0]    next_pos,
  output logic                        keep,
  output logic                        valid_out,
  output logic [tks_pkg::VALUE_W-1:0] value_out,
  output logic [tks_pkg::POS_W-1:0]   pos_out
);
  import tks_pkg::*;

  logic               valid;
  logic [VALUE_W-1:0] value;
  logic [POS_W-1:0]   pos;

  // Existing entry wins ties: it came earlier in the row.
  assign keep      = valid && active && (rank_key(value) >= new_key);
  assign valid_out = valid && active;
  assign value_out = value;
  assign pos_out   = pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= next_valid;
      value <= next_value;
      pos   <= next_pos;
    end else if (ctrl.insert) begin
      if (!active) begin
        valid <= 1'b0;
      end else if (!keep) begin
        if (prev_keep) begin
          valid <= 1'b1;
          value <= new_value;
          pos   <= new_pos;
        end else begin
          valid <= prev_valid;
          value <= prev_value;
          pos   <= prev_pos;
        end
      end
    end else if (ctrl.trim) begin
      valid <= valid && active;
    end
  end
endmodule
`default_nettype wire
